[sv/heartbeat_response_matcher_core_macros.svh]
// Assertion macros for the heartbeat response matcher.
// Included by the top level; no other dependencies.
`ifndef HEARTBEAT_RESPONSE_MATCHER_CORE_MACROS_SVH
`define HEARTBEAT_RESPONSE_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define HRM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hrm assertion failed");

// Next-cycle implication, disabled during reset.
`define HRM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hrm assertion failed");

`endif

[sv/hrm_pkg.sv]
// Shared constants for the heartbeat response matcher.
// No dependencies.
`timescale 1ns / 1ps

package hrm_pkg;
   localparam int SENT_DEPTH_DEF = 16;
   localparam int HELD_DEPTH_DEF = 16;

   localparam int MAGIC_W = 32;
   localparam int TIME_W  = 16;
   localparam int TMO_W   = 15;

   localparam logic [TMO_W-1:0] TMO_RESET = 15'd400;

   localparam logic [1:0] FN_SEND = 2'd0;
   localparam logic [1:0] FN_RESP = 2'd1;
   localparam logic [1:0] FN_TICK = 2'd2;

   localparam logic [2:0] EV_OK       = 3'd0;
   localparam logic [2:0] EV_MATCH    = 3'd1;
   localparam logic [2:0] EV_HELD     = 3'd2;
   localparam logic [2:0] EV_TIMEOUT  = 3'd3;
   localparam logic [2:0] EV_LATE     = 3'd4;
   localparam logic [2:0] EV_DROP     = 3'd5;
   localparam logic [2:0] EV_OVERFLOW = 3'd6;
endpackage

[sv/hrm_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read port.
// Used for the sent and held tables; no dependencies.
`timescale 1ns / 1ps

module hrm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[sv/heartbeat_response_matcher_core.sv]
// Heartbeat response matcher: FSM walking sent and held tables in RAM.
// Depends on hrm_pkg, hrm_ram and the assertion macro header.
// Send: result the cycle after the request, busy stays low.
// Response: searches the sent table entry by entry, shifts later entries down on removal, then reports.
// Tick: scans the sent entries for timeouts, then walks the held entries, an aged one adding its
// search and removal. Results never stall. Reset empties tables, sets timeout to 400.
`timescale 1ns / 1ps
`include "heartbeat_response_matcher_core_macros.svh"

module heartbeat_response_matcher_core #(
   parameter int SENT_DEPTH = hrm_pkg::SENT_DEPTH_DEF,
   parameter int HELD_DEPTH = hrm_pkg::HELD_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_func,
   input  logic [hrm_pkg::MAGIC_W-1:0] req_magic,
   output logic                        rsp_valid,
   output logic [2:0]                  rsp_event_res,
   output logic [hrm_pkg::MAGIC_W-1:0] rsp_event_magic,
   output logic                        rsp_last,
   input  logic                        csr_wr_en,
   input  logic [hrm_pkg::TMO_W-1:0]   csr_wr_data
);
   localparam int SIW = (SENT_DEPTH > 1) ? $clog2(SENT_DEPTH) : 1;
   localparam int SCW = $clog2(SENT_DEPTH + 1);
   localparam int HIW = (HELD_DEPTH > 1) ? $clog2(HELD_DEPTH) : 1;
   localparam int HCW = $clog2(HELD_DEPTH + 1);
   localparam int MW  = hrm_pkg::MAGIC_W;
   localparam int TW  = hrm_pkg::TIME_W;
   localparam int SDW = MW + TW;
   localparam int HDW = MW + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SRCH_RD, ST_SRCH_CHK, ST_REM_RD, ST_REM_WR, ST_RESULT,
      ST_EXP_RD, ST_EXP_CHK, ST_HLD_RD, ST_HLD_CHK
   } state_type;

   state_type state_ff, state_in;
   logic [SCW-1:0] sent_cnt_ff, sent_cnt_in;
   logic [HCW-1:0] held_cnt_ff, held_cnt_in;
   logic [TW-1:0] time_ff, time_in;
   logic [hrm_pkg::TMO_W-1:0] tmo_ff, tmo_in;
   logic [MW-1:0] magic_ff, magic_in;
   logic hld_mode_ff, hld_mode_in;
   logic found_ff, found_in;
   logic [SCW-1:0] idx_ff, idx_in;
   logic [SCW-1:0] si_ff, si_in;
   logic [SCW-1:0] sw_ff, sw_in;
   logic [HCW-1:0] hi_ff, hi_in;
   logic [HCW-1:0] hw_ff, hw_in;
   logic vld_ff, vld_in;
   logic [2:0] ev_ff, ev_in;
   logic [MW-1:0] emag_ff, emag_in;
   logic last_ff, last_in;

   logic s_we;
   logic [SIW-1:0] s_waddr, s_raddr;
   logic [SDW-1:0] s_wdata, s_rdata;
   logic h_we;
   logic [HIW-1:0] h_waddr, h_raddr;
   logic [HDW-1:0] h_wdata, h_rdata;
   logic [TW-1:0] elapsed;
   logic [SCW-1:0] idx_nx;

   hrm_ram #(.WIDTH(SDW), .DEPTH(SENT_DEPTH), .AW(SIW)) u_sent (
      .clock(clock), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
      .raddr(s_raddr), .rdata(s_rdata)
   );

   hrm_ram #(.WIDTH(HDW), .DEPTH(HELD_DEPTH), .AW(HIW)) u_held (
      .clock(clock), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   assign elapsed = time_ff - s_rdata[TW-1:0];
   assign idx_nx  = idx_ff + SCW'(1);

   always_comb begin
      state_in    = state_ff;
      sent_cnt_in = sent_cnt_ff;
      held_cnt_in = held_cnt_ff;
      time_in     = time_ff;
      tmo_in      = csr_wr_en ? csr_wr_data : tmo_ff;
      magic_in    = magic_ff;
      hld_mode_in = hld_mode_ff;
      found_in    = found_ff;
      idx_in      = idx_ff;
      si_in       = si_ff;
      sw_in       = sw_ff;
      hi_in       = hi_ff;
      hw_in       = hw_ff;
      vld_in      = 1'b0;
      ev_in       = hrm_pkg::EV_OK;
      emag_in     = '0;
      last_in     = 1'b0;
      s_we        = 1'b0;
      s_waddr     = '0;
      s_wdata     = '0;
      s_raddr     = '0;
      h_we        = 1'b0;
      h_waddr     = '0;
      h_wdata     = '0;
      h_raddr     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               unique case (req_func)
                  hrm_pkg::FN_SEND: begin
                     vld_in  = 1'b1;
                     emag_in = req_magic;
                     last_in = 1'b1;
                     if (sent_cnt_ff < SCW'(SENT_DEPTH)) begin
                        s_we        = 1'b1;
                        s_waddr     = sent_cnt_ff[SIW-1:0];
                        s_wdata     = {req_magic, time_ff};
                        sent_cnt_in = sent_cnt_ff + SCW'(1);
                        ev_in       = hrm_pkg::EV_OK;
                     end else begin
                        ev_in = hrm_pkg::EV_OVERFLOW;
                     end
                  end
                  hrm_pkg::FN_RESP: begin
                     magic_in    = req_magic;
                     hld_mode_in = 1'b0;
                     idx_in      = '0;
                     state_in    = ST_SRCH_RD;
                  end
                  hrm_pkg::FN_TICK: begin
                     time_in  = time_ff + TW'(1);
                     si_in    = '0;
                     sw_in    = '0;
                     state_in = ST_EXP_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SRCH_RD: begin
            if (idx_ff == sent_cnt_ff) begin
               found_in = 1'b0;
               state_in = ST_RESULT;
            end else begin
               s_raddr  = idx_ff[SIW-1:0];
               state_in = ST_SRCH_CHK;
            end
         end
         ST_SRCH_CHK: begin
            if (s_rdata[SDW-1:TW] == magic_ff) begin
               state_in = ST_REM_RD;
            end else begin
               idx_in   = idx_nx;
               state_in = ST_SRCH_RD;
            end
         end
         ST_REM_RD: begin
            if (idx_nx == sent_cnt_ff) begin
               sent_cnt_in = sent_cnt_ff - SCW'(1);
               found_in    = 1'b1;
               state_in    = ST_RESULT;
            end else begin
               s_raddr  = idx_nx[SIW-1:0];
               state_in = ST_REM_WR;
            end
         end
         ST_REM_WR: begin
            s_we     = 1'b1;
            s_waddr  = idx_ff[SIW-1:0];
            s_wdata  = s_rdata;
            idx_in   = idx_nx;
            state_in = ST_REM_RD;
         end
         ST_RESULT: begin
            vld_in  = 1'b1;
            emag_in = magic_ff;
            if (hld_mode_ff) begin
               ev_in    = found_ff ? hrm_pkg::EV_LATE : hrm_pkg::EV_DROP;
               hi_in    = hi_ff + HCW'(1);
               state_in = ST_HLD_RD;
            end else begin
               last_in  = 1'b1;
               state_in = ST_IDLE;
               if (found_ff) begin
                  ev_in = hrm_pkg::EV_MATCH;
               end else if (held_cnt_ff < HCW'(HELD_DEPTH)) begin
                  h_we        = 1'b1;
                  h_waddr     = held_cnt_ff[HIW-1:0];
                  h_wdata     = {magic_ff, 1'b0};
                  held_cnt_in = held_cnt_ff + HCW'(1);
                  ev_in       = hrm_pkg::EV_HELD;
               end else begin
                  ev_in = hrm_pkg::EV_OVERFLOW;
               end
            end
         end
         ST_EXP_RD: begin
            if (si_ff == sent_cnt_ff) begin
               sent_cnt_in = sw_ff;
               hi_in       = '0;
               hw_in       = '0;
               state_in    = ST_HLD_RD;
            end else begin
               s_raddr  = si_ff[SIW-1:0];
               state_in = ST_EXP_CHK;
            end
         end
         ST_EXP_CHK: begin
            if (elapsed > {1'b0, tmo_ff}) begin
               vld_in  = 1'b1;
               ev_in   = hrm_pkg::EV_TIMEOUT;
               emag_in = s_rdata[SDW-1:TW];
            end else begin
               s_we    = 1'b1;
               s_waddr = sw_ff[SIW-1:0];
               s_wdata = s_rdata;
               sw_in   = sw_ff + SCW'(1);
            end
            si_in    = si_ff + SCW'(1);
            state_in = ST_EXP_RD;
         end
         ST_HLD_RD: begin
            if (hi_ff == held_cnt_ff) begin
               held_cnt_in = hw_ff;
               vld_in      = 1'b1;
               ev_in       = hrm_pkg::EV_OK;
               last_in     = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               h_raddr  = hi_ff[HIW-1:0];
               state_in = ST_HLD_CHK;
            end
         end
         ST_HLD_CHK: begin
            if (!h_rdata[0]) begin
               h_we     = 1'b1;
               h_waddr  = hw_ff[HIW-1:0];
               h_wdata  = {h_rdata[HDW-1:1], 1'b1};
               hw_in    = hw_ff + HCW'(1);
               hi_in    = hi_ff + HCW'(1);
               state_in = ST_HLD_RD;
            end else begin
               magic_in    = h_rdata[HDW-1:1];
               hld_mode_in = 1'b1;
               idx_in      = '0;
               state_in    = ST_SRCH_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         sent_cnt_ff <= '0;
         held_cnt_ff <= '0;
         time_ff     <= '0;
         tmo_ff      <= hrm_pkg::TMO_RESET;
         vld_ff      <= 1'b0;
         hld_mode_ff <= 1'b0;
         found_ff    <= 1'b0;
         idx_ff      <= '0;
         si_ff       <= '0;
         sw_ff       <= '0;
         hi_ff       <= '0;
         hw_ff       <= '0;
      end else begin
         state_ff    <= state_in;
         sent_cnt_ff <= sent_cnt_in;
         held_cnt_ff <= held_cnt_in;
         time_ff     <= time_in;
         tmo_ff      <= tmo_in;
         vld_ff      <= vld_in;
         hld_mode_ff <= hld_mode_in;
         found_ff    <= found_in;
         idx_ff      <= idx_in;
         si_ff       <= si_in;
         sw_ff       <= sw_in;
         hi_ff       <= hi_in;
         hw_ff       <= hw_in;
      end
      magic_ff <= magic_in;
      ev_ff    <= ev_in;
      emag_ff  <= emag_in;
      last_ff  <= last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_valid       = vld_ff;
   assign rsp_event_res   = ev_ff;
   assign rsp_event_magic = emag_ff;
   assign rsp_last        = last_ff;

   `HRM_ASSERT_NEXT(a_tick_busy, clock, reset, start && !busy && req_func == hrm_pkg::FN_TICK, busy)
   `HRM_ASSERT_NOW(a_sent_bound, clock, reset, 1'b1, sent_cnt_ff <= SCW'(SENT_DEPTH))
   `HRM_ASSERT_NOW(a_held_bound, clock, reset, 1'b1, held_cnt_ff <= HCW'(HELD_DEPTH))
   `HRM_ASSERT_NOW(a_more_follows, clock, reset, rsp_valid && !rsp_last, busy)
endmodule

[tb/testbench.sv]
// Self-checking testbench for heartbeat_response_matcher_core.
// Depends on hrm_pkg and the core; predicts every event in-line and checks it on the strobe.
`timescale 1ns / 1ps

module testbench;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SDEPTH = hrm_pkg::SENT_DEPTH_DEF;
   localparam int HDEPTH = hrm_pkg::HELD_DEPTH_DEF;
   localparam logic [1:0] FN_IGNORED = 2'd3;

   typedef struct {
      logic [2:0]  ev;
      logic [31:0] mag;
      logic        fin;
   } hb_event_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [1:0]                req_func = hrm_pkg::FN_SEND;
   logic [31:0]               req_magic = '0;
   logic                      rsp_valid;
   logic [2:0]                rsp_event_res;
   logic [31:0]               rsp_event_magic;
   logic                      rsp_last;
   logic                      csr_wr_en = 1'b0;
   logic [hrm_pkg::TMO_W-1:0] csr_wr_data = '0;

   hb_event_type pending_events[$];
   logic [31:0] sent_mag[SDEPTH];
   logic [15:0] sent_tm[SDEPTH];
   int          sent_n;
   logic [31:0] held_mag[HDEPTH];
   logic        held_aged[HDEPTH];
   int          held_n;
   logic [15:0] tick_now;
   logic [14:0] tmo_now;
   int          error_count = 0;
   int          cycles = 0;
   int          burst_left = 4;
   logic [31:0] magic_pool[8];

   heartbeat_response_matcher_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_magic(req_magic),
      .rsp_valid(rsp_valid), .rsp_event_res(rsp_event_res),
      .rsp_event_magic(rsp_event_magic), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic void push_event(logic [2:0] ev, logic [31:0] m, logic fin);
      hb_event_type e;
      e.ev = ev;
      e.mag = m;
      e.fin = fin;
      pending_events.push_back(e);
   endfunction

   function automatic int find_sent(logic [31:0] m);
      for (int i = 0; i < sent_n; i++)
         if (sent_mag[i] == m) return i;
      return sent_n;
   endfunction

   function automatic void remove_sent(int p);
      for (int i = p; i + 1 < sent_n; i++) begin
         sent_mag[i] = sent_mag[i+1];
         sent_tm[i] = sent_tm[i+1];
      end
      sent_n--;
   endfunction

   function automatic void predict_heartbeat(logic [1:0] fn, logic [31:0] m);
      int w;
      int p;
      logic [15:0] elapsed;
      logic [31:0] hm;
      case (fn)
         hrm_pkg::FN_SEND: begin
            if (sent_n < SDEPTH) begin
               sent_mag[sent_n] = m;
               sent_tm[sent_n] = tick_now;
               sent_n++;
               push_event(hrm_pkg::EV_OK, m, 1'b1);
            end else
               push_event(hrm_pkg::EV_OVERFLOW, m, 1'b1);
         end
         hrm_pkg::FN_RESP: begin
            p = find_sent(m);
            if (p < sent_n) begin
               remove_sent(p);
               push_event(hrm_pkg::EV_MATCH, m, 1'b1);
            end else if (held_n < HDEPTH) begin
               held_mag[held_n] = m;
               held_aged[held_n] = 1'b0;
               held_n++;
               push_event(hrm_pkg::EV_HELD, m, 1'b1);
            end else
               push_event(hrm_pkg::EV_OVERFLOW, m, 1'b1);
         end
         hrm_pkg::FN_TICK: begin
            tick_now = tick_now + 16'd1;
            w = 0;
            for (int i = 0; i < sent_n; i++) begin
               elapsed = tick_now - sent_tm[i];
               if (elapsed > {1'b0, tmo_now})
                  push_event(hrm_pkg::EV_TIMEOUT, sent_mag[i], 1'b0);
               else begin
                  sent_mag[w] = sent_mag[i];
                  sent_tm[w] = sent_tm[i];
                  w++;
               end
            end
            sent_n = w;
            w = 0;
            for (int i = 0; i < held_n; i++) begin
               hm = held_mag[i];
               if (!held_aged[i]) begin
                  held_mag[w] = hm;
                  held_aged[w] = 1'b1;
                  w++;
               end else begin
                  p = find_sent(hm);
                  if (p < sent_n) begin
                     remove_sent(p);
                     push_event(hrm_pkg::EV_LATE, hm, 1'b0);
                  end else
                     push_event(hrm_pkg::EV_DROP, hm, 1'b0);
               end
            end
            held_n = w;
            push_event(hrm_pkg::EV_OK, 32'd0, 1'b1);
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      hb_event_type e;
      if (!reset && rsp_valid) begin
         if (pending_events.size() == 0) begin
            $error("unexpected item: event_res %0d event_magic %h", rsp_event_res,
                   rsp_event_magic);
            error_count++;
         end else begin
            e = pending_events.pop_front();
            if (rsp_event_res !== e.ev) begin
               $error("event_res expected %0d actual %0d", e.ev, rsp_event_res);
               error_count++;
            end
            if (rsp_event_magic !== e.mag) begin
               $error("event_magic expected %h actual %h", e.mag, rsp_event_magic);
               error_count++;
            end
            if (rsp_last !== e.fin) begin
               $error("last expected %0d actual %0d", e.fin, rsp_last);
               error_count++;
            end
         end
      end
   end

   task automatic send_item(logic [1:0] fn, logic [31:0] m);
      int gap;
      start <= 1'b1;
      req_func <= fn;
      req_magic <= m;
      do @(posedge clock); while (busy !== 1'b0);
      predict_heartbeat(fn, m);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 8);
         gap = $urandom_range(0, 7);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_events();
      start <= 1'b0;
      do @(posedge clock); while (pending_events.size() != 0 || busy !== 1'b0);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_timeout(logic [14:0] v);
      drain_events();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tmo_now = v;
   endtask

   task automatic test_default_timeout();
      send_item(hrm_pkg::FN_SEND, 32'h1234_5678);
      repeat (401) send_item(hrm_pkg::FN_TICK, $urandom());
      drain_events();
   endtask

   task automatic test_directed();
      send_item(hrm_pkg::FN_SEND, 32'h0000_0000);
      send_item(hrm_pkg::FN_SEND, 32'hFFFF_FFFF);
      send_item(hrm_pkg::FN_RESP, 32'hFFFF_FFFF);
      send_item(hrm_pkg::FN_RESP, 32'h0000_0000);
      send_item(hrm_pkg::FN_RESP, 32'hA5A5_5A5A);
      send_item(hrm_pkg::FN_RESP, 32'h5A5A_A5A5);
      send_item(hrm_pkg::FN_TICK, 32'hFFFF_FFFF);
      send_item(hrm_pkg::FN_SEND, 32'hA5A5_5A5A);
      send_item(hrm_pkg::FN_TICK, 32'h0);
      send_item(FN_IGNORED, 32'hDEAD_BEEF);
      send_item(FN_IGNORED, 32'h0);
      drain_events();
   endtask

   task automatic test_overflow();
      for (int i = 0; i < SDEPTH + 2; i++) send_item(hrm_pkg::FN_SEND, 32'h100 + i);
      for (int i = 0; i < HDEPTH + 2; i++) send_item(hrm_pkg::FN_RESP, 32'h200 + i);
      send_item(hrm_pkg::FN_RESP, 32'h105);
      send_item(hrm_pkg::FN_TICK, 32'h0);
      send_item(hrm_pkg::FN_TICK, 32'h0);
      drain_events();
   endtask

   task automatic test_zero_timeout();
      write_timeout(15'd0);
      send_item(hrm_pkg::FN_SEND, 32'hCAFE_0001);
      send_item(hrm_pkg::FN_SEND, 32'hCAFE_0002);
      send_item(hrm_pkg::FN_TICK, 32'h0);
      write_timeout(15'd32767);
      send_item(hrm_pkg::FN_SEND, 32'hCAFE_0003);
      repeat (5) send_item(hrm_pkg::FN_TICK, 32'h0);
      send_item(hrm_pkg::FN_RESP, 32'hCAFE_0003);
      drain_events();
   endtask

   task automatic test_random_traffic();
      int r;
      logic [31:0] m;
      for (int phase = 0; phase < 4; phase++) begin
         write_timeout(phase == 3 ? 15'($urandom_range(1, 32767))
                                  : 15'($urandom_range(1, 10)));
         foreach (magic_pool[i]) magic_pool[i] = $urandom();
         for (int n = 0; n < 10; n++) begin
            m = ($urandom_range(0, 4) == 0) ? $urandom() : magic_pool[$urandom_range(0, 7)];
            r = $urandom_range(0, 99);
            if (r < 36) send_item(hrm_pkg::FN_SEND, m);
            else if (r < 70) send_item(hrm_pkg::FN_RESP, m);
            else if (r < 96) send_item(hrm_pkg::FN_TICK, $urandom());
            else send_item(FN_IGNORED, $urandom());
         end
         drain_events();
      end
   endtask

   initial begin
      sent_n = 0;
      held_n = 0;
      tick_now = '0;
      tmo_now = hrm_pkg::TMO_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_default_timeout();
      test_directed();
      test_overflow();
      test_zero_timeout();
      test_random_traffic();
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
